FILE: src/bstk_pkg.sv
// Shared request and outcome codes and controller/datapath interface types for the stack.
package bstk_pkg;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_PEEK   = 3'd2;
    localparam logic [2:0] REQ_STATUS = 3'd3;
    localparam logic [2:0] REQ_MAX    = 3'd4;
    localparam logic [2:0] REQ_EVEN   = 3'd5;
    localparam logic [2:0] REQ_ODD    = 3'd6;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam logic [1:0] OUT_OK    = 2'd0;
    localparam logic [1:0] OUT_FULL  = 2'd1;
    localparam logic [1:0] OUT_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // request taken this cycle
        logic immediate;  // request is answered without a memory walk
        logic issue;      // read the entry at the scan index
        logic final_res;  // give the closing word of a walk
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic scan_end;   // scan index points at the top entry
    } t_dp_stat;

endpackage

FILE: src/bstk_ctrl.sv
// Controller state machine that sequences the memory walk for scan requests.
module bstk_ctrl
    import bstk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_req_type,
    input  t_dp_stat   i_stat,
    output t_ctl_cmd   o_cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   imm;

    // Push and the unused code never read the memory, nor does anything on an empty stack.
    assign imm = (i_req_type == REQ_PUSH) || (i_req_type == REQ_UNUSED) || i_stat.empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && !imm) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                if (i_stat.scan_end) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cmd.accept    = start && (r_state == S_IDLE);
    assign o_cmd.immediate = imm;
    assign o_cmd.issue     = (r_state == S_ISSUE);
    assign o_cmd.final_res = (r_state == S_FIN);

    a_drain_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_FIN))
        else $error("drain not followed by final word");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE))
        else $error("final word not followed by idle");

    a_imm_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && imm) |=> (r_state == S_IDLE))
        else $error("immediate request left idle");

endmodule

FILE: src/bstk_dpath.sv
// Datapath: stack memory, fill count, scan index, held word and result registers.
module bstk_dpath
    import bstk_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    input  t_ctl_cmd           i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_valid,
    output logic [1:0]         o_outcome,
    output logic               o_has_value,
    output logic signed [31:0] o_data_value,
    output logic [3:0]         o_element_count,
    output logic [3:0]         o_free_slots,
    output logic               o_last_result
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int EXT_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(STACK_DEPTH);
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(STACK_DEPTH);

    logic signed [31:0] r_mem [STACK_DEPTH];
    logic signed [31:0] r_rd_data;
    logic               r_rd_vld;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [AW-1:0]      r_idx;
    logic [2:0]         r_req;
    logic signed [31:0] r_pend;
    logic               r_pend_vld;

    logic               r_valid;
    logic [1:0]         r_outcome;
    logic               r_has;
    logic signed [31:0] r_data;
    logic [3:0]         r_cnt4;
    logic [3:0]         r_free4;
    logic               r_last;

    logic               full;
    logic               list_mode, status_mode, max_mode;
    logic               take;
    logic [1:0]         walk_outcome;
    logic               emit;
    logic [1:0]         e_outcome;
    logic               e_has;
    logic signed [31:0] e_data;
    logic               e_last;
    logic               do_push;
    logic [EXT_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   top_idx;

    assign full     = (r_count == DEPTH_C);
    assign top_idx  = r_count - CNT_W'(1);
    assign do_push  = i_cmd.accept && i_cmd.immediate && (i_req_type == REQ_PUSH) && !full;

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.scan_end = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign status_mode = (r_req == REQ_STATUS);
    assign max_mode    = (r_req == REQ_MAX);
    assign list_mode   = (r_req == REQ_EVEN) || (r_req == REQ_ODD);
    assign walk_outcome = (status_mode && full) ? OUT_FULL : OUT_OK;

    // Whether the word just read replaces the held word.
    always_comb begin
        take = 1'b1;
        if (max_mode) begin
            take = !r_pend_vld || (r_rd_data > r_pend);
        end else if (list_mode) begin
            take = (r_rd_data[0] == (r_req == REQ_ODD));
        end
    end

    // Emits immediate and closing words, and a held word after a later match.
    always_comb begin
        emit      = 1'b0;
        e_outcome = OUT_OK;
        e_has     = 1'b0;
        e_data    = '0;
        e_last    = 1'b1;
        n_count   = r_count;
        if (i_cmd.accept && i_cmd.immediate) begin
            emit = 1'b1;
            if (i_req_type == REQ_PUSH) begin
                if (full) begin
                    e_outcome = OUT_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (i_req_type != REQ_UNUSED) begin
                e_outcome = OUT_EMPTY;
            end
        end else if (i_cmd.final_res) begin
            emit      = 1'b1;
            e_outcome = walk_outcome;
            e_has     = r_pend_vld;
            e_data    = r_pend_vld ? r_pend : 32'sd0;
            if (r_req == REQ_POP) n_count = top_idx;
        end else if (r_rd_vld && take && r_pend_vld && (status_mode || list_mode)) begin
            emit      = 1'b1;
            e_outcome = walk_outcome;
            e_has     = 1'b1;
            e_data    = r_pend;
            e_last    = 1'b0;
        end
    end

    assign cnt_ext = EXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_count[AW-1:0]] <= i_push_value;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.issue;
            r_valid  <= emit;
            if (i_cmd.accept && !i_cmd.immediate) begin
                r_pend_vld <= 1'b0;
            end else if (r_rd_vld && take) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_cmd.immediate) begin
            r_req <= i_req_type;
            r_idx <= ((i_req_type == REQ_POP) || (i_req_type == REQ_PEEK)) ?
                     top_idx[AW-1:0] : '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + AW'(1);
        end
        if (r_rd_vld && take) begin
            r_pend <= r_rd_data;
        end
        if (emit) begin
            r_outcome <= e_outcome;
            r_has     <= e_has;
            r_data    <= e_data;
            r_last    <= e_last;
            r_cnt4    <= cnt_ext[3:0];
            r_free4   <= 4'(DEPTH_EXT - cnt_ext);
        end
    end

    assign o_valid         = r_valid;
    assign o_outcome       = r_outcome;
    assign o_has_value     = r_has;
    assign o_data_value    = r_data;
    assign o_element_count = r_cnt4;
    assign o_free_slots    = r_free4;
    assign o_last_result   = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count beyond depth");

    a_no_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has) |-> (r_data == 32'sd0))
        else $error("data word set without a value");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow the stack");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.final_res |=> (r_valid && r_last))
        else $error("walk closed without a last word");

endmodule

FILE: src/bounded_stack_with_scans.sv
// Top level of the bounded LIFO stack with maximum and list scans.
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy accepts     i_req_type, i_push_value
//  result    out        o_valid, one cycle each   o_outcome, o_has_value, o_data_value,
//                                                 o_element_count, o_free_slots,
//                                                 o_last_result
//
// Push, the unused code and any request on an empty stack answer in the cycle after
// acceptance, and busy stays low so another request may follow at once.
// Pop, peek, maximum, status and list requests walk the memory one entry a cycle through
// its single registered read port (pop and peek the top entry only, the rest every filled
// entry); busy covers the walk, and the last word is shown in the cycle busy falls.
// Reset is synchronous and active low; it empties the stack, memory contents stay as they are.
// Result words cannot be stalled; each is shown for exactly one cycle.
module bounded_stack_with_scans
    import bstk_pkg::*;
#(
    parameter int STACK_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    output logic               o_valid,
    output logic [1:0]         o_outcome,
    output logic               o_has_value,
    output logic signed [31:0] o_data_value,
    output logic [3:0]         o_element_count,
    output logic [3:0]         o_free_slots,
    output logic               o_last_result
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    bstk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    bstk_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_outcome       (o_outcome),
        .o_has_value     (o_has_value),
        .o_data_value    (o_data_value),
        .o_element_count (o_element_count),
        .o_free_slots    (o_free_slots),
        .o_last_result   (o_last_result)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded stack with push, pop, peek, status and scan requests.
module testbench;
    import bstk_pkg::*;

    localparam int DEPTH         = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_BLOCKS = 10;
    localparam int BLOCK_ITEMS   = 20;

    typedef struct packed {
        logic [2:0]         req;
        logic signed [31:0] value;
    } stack_req_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               has_value;
        logic signed [31:0] data_value;
        logic [3:0]         element_count;
        logic [3:0]         free_slots;
        logic               last_result;
    } stack_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_req_type = REQ_PUSH;
    logic signed [31:0] i_push_value = '0;
    logic               o_valid;
    logic [1:0]         o_outcome;
    logic               o_has_value;
    logic signed [31:0] o_data_value;
    logic [3:0]         o_element_count;
    logic [3:0]         o_free_slots;
    logic               o_last_result;

    stack_req_t         pending_reqs[$];
    stack_word_t        expected_words[$];
    logic signed [31:0] shadow_mem [DEPTH];
    int                 shadow_fill = 0;
    int                 mismatch_count = 0;
    int                 reset_cycles = 0;
    int                 gap_left = 0;
    int                 no_idle_left = 0;

    bounded_stack_with_scans #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .o_valid         (o_valid),
        .o_outcome       (o_outcome),
        .o_has_value     (o_has_value),
        .o_data_value    (o_data_value),
        .o_element_count (o_element_count),
        .o_free_slots    (o_free_slots),
        .o_last_result   (o_last_result)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (reset_cycles < RESET_CYCLES) begin
            reset_cycles <= reset_cycles + 1;
        end else begin
            i_rst_n <= 1'b1;
        end
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic queue_req(input logic [2:0] req, input logic signed [31:0] value);
        pending_reqs.push_back('{req, value});
    endtask

    // Counts reflect the stack after the request has taken effect.
    function automatic stack_word_t make_word(input logic [1:0] outcome, input logic has,
                                              input logic signed [31:0] value,
                                              input logic last);
        stack_word_t w;
        w.outcome       = outcome;
        w.has_value     = has;
        w.data_value    = has ? value : '0;
        w.element_count = shadow_fill[3:0];
        w.free_slots    = 4'(DEPTH - shadow_fill);
        w.last_result   = last;
        return w;
    endfunction

    task automatic predict_request(input logic [2:0] req, input logic signed [31:0] value);
        logic signed [31:0] best;
        logic               want_odd;
        int                 match_total;
        int                 k;
        if (req == REQ_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                expected_words.push_back(make_word(OUT_FULL, 1'b0, '0, 1'b1));
            end else begin
                shadow_mem[shadow_fill] = value;
                shadow_fill++;
                expected_words.push_back(make_word(OUT_OK, 1'b0, '0, 1'b1));
            end
        end else if (req == REQ_UNUSED) begin
            expected_words.push_back(make_word(OUT_OK, 1'b0, '0, 1'b1));
        end else if (shadow_fill == 0) begin
            expected_words.push_back(make_word(OUT_EMPTY, 1'b0, '0, 1'b1));
        end else begin
            case (req)
                REQ_POP: begin
                    shadow_fill--;
                    expected_words.push_back(make_word(OUT_OK, 1'b1,
                                                       shadow_mem[shadow_fill], 1'b1));
                end
                REQ_PEEK: begin
                    expected_words.push_back(make_word(OUT_OK, 1'b1,
                                                       shadow_mem[shadow_fill - 1], 1'b1));
                end
                REQ_STATUS: begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        expected_words.push_back(make_word(
                            (shadow_fill == DEPTH) ? OUT_FULL : OUT_OK, 1'b1,
                            shadow_mem[i], i == shadow_fill - 1));
                    end
                end
                REQ_MAX: begin
                    best = shadow_mem[0];
                    for (int i = 1; i < shadow_fill; i++) begin
                        if (shadow_mem[i] > best) best = shadow_mem[i];
                    end
                    expected_words.push_back(make_word(OUT_OK, 1'b1, best, 1'b1));
                end
                default: begin
                    // Even and odd lists go by the low bit, negative values included.
                    want_odd = (req == REQ_ODD);
                    match_total = 0;
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_mem[i][0] == want_odd) match_total++;
                    end
                    if (match_total == 0) begin
                        expected_words.push_back(make_word(OUT_OK, 1'b0, '0, 1'b1));
                    end else begin
                        k = 0;
                        for (int i = 0; i < shadow_fill; i++) begin
                            if (shadow_mem[i][0] == want_odd) begin
                                k++;
                                expected_words.push_back(make_word(OUT_OK, 1'b1,
                                                                   shadow_mem[i],
                                                                   k == match_total));
                            end
                        end
                    end
                end
            endcase
        end
    endtask

    // Request driver: one word is accepted at each edge where start is high and busy is low.
    always @(posedge i_clk) begin
        stack_req_t nxt;
        int         gap;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            predict_request(i_req_type, i_push_value);
            if (no_idle_left > 0) begin
                no_idle_left <= no_idle_left - 1;
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                no_idle_left <= $urandom_range(10, 30);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 8);
            end
            if (gap == 0 && pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                i_req_type <= nxt.req;
                i_push_value <= nxt.value;
            end else begin
                start <= 1'b0;
                gap_left <= gap;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                i_req_type <= nxt.req;
                i_push_value <= nxt.value;
                start <= 1'b1;
            end
        end
    end

    // Result checker: every strobed word is compared with the oldest expected word.
    always @(posedge i_clk) begin
        stack_word_t got;
        stack_word_t want;
        if (i_rst_n && o_valid) begin
            got = '{o_outcome, o_has_value, o_data_value, o_element_count, o_free_slots,
                    o_last_result};
            if (expected_words.size() == 0) begin
                note_failure($sformatf("unexpected word: outcome %0d has %0b data %0d",
                                       got.outcome, got.has_value, got.data_value));
            end else begin
                want = expected_words.pop_front();
                if (got.outcome !== want.outcome || got.has_value !== want.has_value ||
                    got.data_value !== want.data_value ||
                    got.element_count !== want.element_count ||
                    got.free_slots !== want.free_slots ||
                    got.last_result !== want.last_result) begin
                    note_failure($sformatf(
                        {"word mismatch: exp outcome %0d has %0b data %0d count %0d free %0d",
                         " last %0b / got outcome %0d has %0b data %0d count %0d free %0d",
                         " last %0b"},
                        want.outcome, want.has_value, want.data_value, want.element_count,
                        want.free_slots, want.last_result, got.outcome, got.has_value,
                        got.data_value, got.element_count, got.free_slots,
                        got.last_result));
                end
            end
        end
    end

    initial begin
        int                 push_pct;
        int                 roll;
        int                 waited;
        logic [2:0]         req;
        logic signed [31:0] value;

        // Every request but push on the empty stack, the unused code included.
        queue_req(REQ_POP, 32'sd0);
        queue_req(REQ_PEEK, 32'sd0);
        queue_req(REQ_STATUS, 32'sd0);
        queue_req(REQ_MAX, 32'sd0);
        queue_req(REQ_EVEN, 32'sd0);
        queue_req(REQ_ODD, 32'sd0);
        queue_req(REQ_UNUSED, 32'h1234_5678);
        // An even list with no match, then a maximum over negative values.
        queue_req(REQ_PUSH, -32'sd1);
        queue_req(REQ_EVEN, 32'sd0);
        queue_req(REQ_PUSH, 32'h8000_0000);
        queue_req(REQ_MAX, 32'sd0);
        queue_req(REQ_ODD, 32'sd0);
        // Fill to the top, then push once more onto the full stack.
        queue_req(REQ_PUSH, 32'h7FFF_FFFF);
        queue_req(REQ_PUSH, 32'sd0);
        queue_req(REQ_PUSH, 32'sd2);
        queue_req(REQ_PUSH, -32'sd2);
        queue_req(REQ_PUSH, 32'sd5);
        queue_req(REQ_PUSH, 32'h5555_5555);
        queue_req(REQ_PUSH, 32'hAAAA_AAAA);
        queue_req(REQ_STATUS, 32'sd0);
        queue_req(REQ_MAX, 32'sd0);
        queue_req(REQ_EVEN, 32'sd0);
        queue_req(REQ_ODD, 32'sd0);
        queue_req(REQ_PEEK, 32'sd0);
        queue_req(REQ_POP, 32'sd0);

        // Blocks alternate between filling and draining so both ends are hit often.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            push_pct = (blk % 2 == 0) ? $urandom_range(60, 85) : $urandom_range(10, 35);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) begin
                    req = REQ_PUSH;
                end else if (roll < push_pct + (100 - push_pct) / 3) begin
                    req = REQ_POP;
                end else if ($urandom_range(0, 19) == 0) begin
                    req = REQ_UNUSED;
                end else begin
                    req = 3'($urandom_range(REQ_PEEK, REQ_ODD));
                end
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: value = 32'h8000_0000;
                            1: value = 32'h7FFF_FFFF;
                            2: value = 32'sd0;
                            default: value = -32'sd1;
                        endcase
                    end
                    1, 2, 3: value = $signed(32'($urandom_range(0, 15))) - 32'sd8;
                    default: value = $urandom;
                endcase
                queue_req(req, value);
            end
        end

        while (pending_reqs.size() > 0 || start) @(posedge i_clk);
        waited = 0;
        while (expected_words.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_words.size() > 0) begin
            note_failure($sformatf("%0d expected words never arrived",
                                   expected_words.size()));
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: bounded_stack_with_scans.f
src/bstk_pkg.sv
src/bstk_ctrl.sv
src/bstk_dpath.sv
src/bounded_stack_with_scans.sv
tb/sv/testbench.sv
